// ===== hw/rtl/dtsa_pkg.sv =====
// Package for the triangulated surface area unit.
// Holds field widths, the register map and the geometry bundle.
// No dependencies.
package dtsa_pkg;

   localparam int MAX_COLUMNS_DEFAULT = 4096;
   localparam int ELEV_W  = 24;
   localparam int SPACE_W = 24;
   localparam int COLS_W  = 13;
   localparam int AREA_W  = 63;
   localparam int RAD_W   = 128;
   localparam int ROOT_W  = 64;

   localparam logic [AREA_W-1:0] AREA_MAX = '1;

   typedef enum logic [2:0] {
      REG_COLUMNS  = 3'd0,
      REG_EW       = 3'd1,
      REG_NS       = 3'd2,
      REG_SCALE    = 3'd3,
      REG_DIAGONAL = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [SPACE_W-1:0] ew;
      logic [SPACE_W-1:0] ns;
      logic [SPACE_W-1:0] scale;
   } geom_type;

endpackage

// ===== hw/rtl/dem_triangulated_surface_area_unit.sv =====
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_elevation, req_last_of_map
// rsp       out        rsp_valid/rsp_stall   rsp_total_area
// csr       in         psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// A sample in the first row or first column computes no area. Any other sample
// computes two triangles, each with a launch, a pass through the shared
// multiplier and a pass through the square root unit. The last sample also passes through the emit state.
// Reset is synchronous; the line store holds no reset value and is not cleared.
// A pending result does not block input, except that a last sample waits for it.
// Top level of the triangulated surface area unit. Uses dtsa_pkg, dtsa_ram,
// dtsa_tri and dtsa_sqrt.
module dem_triangulated_surface_area_unit import dtsa_pkg::*; #(
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [ELEV_W-1:0] req_elevation,
   input  logic                     req_last_of_map,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [AREA_W-1:0]        rsp_total_area,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [4:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   localparam int AW = $clog2(MAX_COLUMNS);
   localparam int CW = $clog2(MAX_COLUMNS + 1);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_READ   = 6'b000010,
      S_LAUNCH = 6'b000100,
      S_TRI    = 6'b001000,
      S_ROOT   = 6'b010000,
      S_EMIT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [COLS_W-1:0]  cols_cfg_ff;
   geom_type           geom_ff;
   logic               diag_ff;

   logic signed [ELEV_W-1:0] left_cur_ff, left_above_ff, top_right_ff, elev_ff;
   logic               last_ff;
   logic [AW-1:0]      col_ff, cur_col_ff;
   logic               first_row_ff;
   logic [AREA_W-1:0]  sum_ff;
   logic               tri_sel_ff;
   logic               rsp_valid_ff;
   logic [AREA_W-1:0]  rsp_area_ff;

   logic               accept, cfg_write, commit, rsp_free;
   logic [31:0]        cols32;
   logic [CW-1:0]      cols;
   logic [AW-1:0]      col_eff;
   logic [CW-1:0]      col_next;
   logic [ELEV_W-1:0]  rd_data;
   logic signed [ELEV_W-1:0] p_v, q_v, r_v;
   logic [ELEV_W-1:0]  mag_n, mag_e;
   logic               tri_start, tri_done, sqrt_done;
   logic [RAD_W-1:0]   radicand;
   logic [ROOT_W-1:0]  root;
   logic [64:0]        sum_wide;
   logic               need_area;

   function automatic logic [ELEV_W-1:0] abs_diff(logic signed [ELEV_W-1:0] a,
                                                  logic signed [ELEV_W-1:0] b);
      logic signed [ELEV_W:0] d;
      d = $signed({a[ELEV_W-1], a}) - $signed({b[ELEV_W-1], b});
      return d[ELEV_W] ? ELEV_W'(-d) : d[ELEV_W-1:0];
   endfunction

   assign accept    = req_valid && !req_stall;
   assign cfg_write = psel && penable && pwrite;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign pready    = 1'b1;

   assign cols32 = (32'(cols_cfg_ff) < 32'd2) ? 32'd2 :
                   (32'(cols_cfg_ff) > 32'(MAX_COLUMNS)) ? 32'(MAX_COLUMNS) :
                   32'(cols_cfg_ff);
   assign cols    = cols32[CW-1:0];
   assign col_eff = (CW'(col_ff) >= cols) ? '0 : col_ff;
   assign col_next = CW'(cur_col_ff) + CW'(1);

   assign need_area = !first_row_ff && (cur_col_ff != '0);

   always_comb begin
      unique case ({diag_ff, tri_sel_ff})
         2'b00:   begin p_v = left_above_ff; q_v = top_right_ff;  r_v = left_cur_ff;  end
         2'b01:   begin p_v = elev_ff;       q_v = left_cur_ff;   r_v = top_right_ff; end
         2'b10:   begin p_v = top_right_ff;  q_v = left_above_ff; r_v = elev_ff;      end
         default: begin p_v = left_cur_ff;   q_v = elev_ff;       r_v = left_above_ff; end
      endcase
   end

   assign mag_n = abs_diff(p_v, q_v);
   assign mag_e = abs_diff(p_v, r_v);

   assign sum_wide = {2'b0, sum_ff} + {1'b0, root};

   always_comb begin
      state_in  = state_ff;
      tri_start = 1'b0;
      commit    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_READ;
         end
         S_READ: begin
            state_in = S_LAUNCH;
         end
         S_LAUNCH: begin
            if (need_area) begin
               tri_start = 1'b1;
               state_in  = S_TRI;
            end else begin
               commit   = 1'b1;
               state_in = last_ff ? S_EMIT : S_IDLE;
            end
         end
         S_TRI: begin
            if (tri_done) state_in = S_ROOT;
         end
         S_ROOT: begin
            if (sqrt_done) begin
               if (!tri_sel_ff) begin
                  state_in = S_LAUNCH;
               end else begin
                  commit   = 1'b1;
                  state_in = last_ff ? S_EMIT : S_IDLE;
               end
            end
         end
         S_EMIT: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cols_cfg_ff   <= COLS_W'(MAX_COLUMNS_DEFAULT);
         geom_ff.ew    <= SPACE_W'(256);
         geom_ff.ns    <= SPACE_W'(256);
         geom_ff.scale <= SPACE_W'(65536);
         diag_ff       <= 1'b0;
         left_cur_ff   <= '0;
         left_above_ff <= '0;
         col_ff        <= '0;
         first_row_ff  <= 1'b1;
         sum_ff        <= '0;
         tri_sel_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cfg_write) begin
            unique case (reg_index_type'(paddr[4:2]))
               REG_COLUMNS:  cols_cfg_ff   <= pwdata[COLS_W-1:0];
               REG_EW:       geom_ff.ew    <= pwdata[SPACE_W-1:0];
               REG_NS:       geom_ff.ns    <= pwdata[SPACE_W-1:0];
               REG_SCALE:    geom_ff.scale <= pwdata[SPACE_W-1:0];
               REG_DIAGONAL: diag_ff       <= pwdata[0];
               default: ;
            endcase
         end
         if (accept) begin
            tri_sel_ff <= 1'b0;
         end
         if (state_ff == S_ROOT && sqrt_done) begin
            sum_ff     <= (sum_wide > {2'b0, AREA_MAX}) ? AREA_MAX : sum_wide[AREA_W-1:0];
            tri_sel_ff <= 1'b1;
         end
         if (commit) begin
            left_above_ff <= top_right_ff;
            left_cur_ff   <= elev_ff;
            if (col_next >= cols) begin
               col_ff       <= '0;
               first_row_ff <= 1'b0;
            end else begin
               col_ff <= col_next[AW-1:0];
            end
         end
         if (state_ff == S_EMIT && rsp_free) begin
            rsp_valid_ff  <= 1'b1;
            left_cur_ff   <= '0;
            left_above_ff <= '0;
            col_ff        <= '0;
            first_row_ff  <= 1'b1;
            sum_ff        <= '0;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         elev_ff    <= req_elevation;
         last_ff    <= req_last_of_map;
         cur_col_ff <= col_eff;
      end
      if (state_ff == S_READ) begin
         top_right_ff <= rd_data;
      end
      if (state_ff == S_EMIT && rsp_free) begin
         rsp_area_ff <= sum_ff;
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_index_type'(paddr[4:2]))
         REG_COLUMNS:  prdata = 32'(cols_cfg_ff);
         REG_EW:       prdata = 32'(geom_ff.ew);
         REG_NS:       prdata = 32'(geom_ff.ns);
         REG_SCALE:    prdata = 32'(geom_ff.scale);
         REG_DIAGONAL: prdata = 32'(diag_ff);
         default:      prdata = '0;
      endcase
   end

   dtsa_ram #(
      .WIDTH (ELEV_W),
      .DEPTH (MAX_COLUMNS)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (cur_col_ff),
      .wr_data (elev_ff),
      .rd_en   (accept),
      .rd_addr (col_eff),
      .rd_data (rd_data)
   );

   dtsa_tri u_tri (
      .clock    (clock),
      .reset    (reset),
      .start    (tri_start),
      .geom     (geom_ff),
      .mag_n    (mag_n),
      .mag_e    (mag_e),
      .done     (tri_done),
      .radicand (radicand)
   );

   dtsa_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_TRI && tri_done),
      .radicand (radicand),
      .done     (sqrt_done),
      .root     (root)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_total_area = rsp_area_ff;

endmodule

// ===== hw/rtl/dtsa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module dtsa_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/dtsa_tri.sv =====
// Triangle component unit: builds the sum of the squared cross-product terms
// of one triangle with one shared 32x32 multiplier. Uses dtsa_pkg.
module dtsa_tri import dtsa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  geom_type             geom,
   input  logic [ELEV_W-1:0]    mag_n,
   input  logic [ELEV_W-1:0]    mag_e,
   output logic                 done,
   output logic [RAD_W-1:0]     radicand
);

   typedef enum logic [3:0] {
      D_NONE, D_K1, D_K2, D_K3, D_T1SET, D_T1HI, D_T2SET, D_T2HI,
      D_RSET, D_R0, D_R33, D_R64
   } dest_type;

   logic [4:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] prod_ff;
   dest_type    dst_ff;
   logic [47:0] k1_ff, k2_ff, k3_ff;
   logic [71:0] t1_ff, t2_ff;
   logic [RAD_W-1:0] r_ff;

   logic [31:0] mul_a, mul_b;
   dest_type    dst;
   logic [62:0] h1, h2;
   logic [46:0] h3;
   logic [RAD_W-1:0] prod_w;

   assign h1 = t1_ff[71:9];
   assign h2 = t2_ff[71:9];
   assign h3 = k3_ff[47:1];
   assign prod_w = {64'b0, prod_ff};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      dst   = D_NONE;
      if (busy_ff) begin
         unique case (step_ff)
            5'd0: begin mul_a = {8'b0, geom.ns}; mul_b = {8'b0, geom.scale}; dst = D_K1; end
            5'd1: begin mul_a = {8'b0, geom.ew}; mul_b = {8'b0, geom.scale}; dst = D_K2; end
            5'd2: begin mul_a = {8'b0, geom.ew}; mul_b = {8'b0, geom.ns}; dst = D_K3; end
            5'd3: begin mul_a = k1_ff[31:0]; mul_b = {8'b0, mag_n}; dst = D_T1SET; end
            5'd4: begin mul_a = {16'b0, k1_ff[47:32]}; mul_b = {8'b0, mag_n}; dst = D_T1HI; end
            5'd5: begin mul_a = k2_ff[31:0]; mul_b = {8'b0, mag_e}; dst = D_T2SET; end
            5'd6: begin mul_a = {16'b0, k2_ff[47:32]}; mul_b = {8'b0, mag_e}; dst = D_T2HI; end
            5'd7: begin mul_a = h1[31:0]; mul_b = h1[31:0]; dst = D_RSET; end
            5'd8: begin mul_a = h1[31:0]; mul_b = {1'b0, h1[62:32]}; dst = D_R33; end
            5'd9: begin mul_a = {1'b0, h1[62:32]}; mul_b = {1'b0, h1[62:32]}; dst = D_R64; end
            5'd10: begin mul_a = h2[31:0]; mul_b = h2[31:0]; dst = D_R0; end
            5'd11: begin mul_a = h2[31:0]; mul_b = {1'b0, h2[62:32]}; dst = D_R33; end
            5'd12: begin mul_a = {1'b0, h2[62:32]}; mul_b = {1'b0, h2[62:32]}; dst = D_R64; end
            5'd13: begin mul_a = h3[31:0]; mul_b = h3[31:0]; dst = D_R0; end
            5'd14: begin mul_a = h3[31:0]; mul_b = {17'b0, h3[46:32]}; dst = D_R33; end
            5'd15: begin mul_a = {17'b0, h3[46:32]}; mul_b = {17'b0, h3[46:32]}; dst = D_R64; end
            default: begin mul_a = '0; mul_b = '0; dst = D_NONE; end
         endcase
      end
   end

   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (step_ff == 5'd16) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         dst_ff  <= D_NONE;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
         dst_ff  <= dst;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      unique case (dst_ff)
         D_K1:    k1_ff <= prod_ff[47:0];
         D_K2:    k2_ff <= prod_ff[47:0];
         D_K3:    k3_ff <= prod_ff[47:0];
         D_T1SET: t1_ff <= {8'b0, prod_ff};
         D_T1HI:  t1_ff <= t1_ff + {prod_ff[39:0], 32'b0};
         D_T2SET: t2_ff <= {8'b0, prod_ff};
         D_T2HI:  t2_ff <= t2_ff + {prod_ff[39:0], 32'b0};
         D_RSET:  r_ff  <= prod_w;
         D_R0:    r_ff  <= r_ff + prod_w;
         D_R33:   r_ff  <= r_ff + (prod_w << 33);
         D_R64:   r_ff  <= r_ff + (prod_w << 64);
         default: ;
      endcase
   end

   assign done     = done_ff;
   assign radicand = r_ff;

endmodule

// ===== hw/rtl/dtsa_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
// Uses dtsa_pkg.
module dtsa_sqrt import dtsa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   logic [RAD_W-1:0]  rad_ff;
   logic [65:0]       rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [5:0]        cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [67:0]       rem_sh;
   logic [67:0]       trial;
   logic              take;

   assign rem_sh = {rem_ff, rad_ff[RAD_W-1:RAD_W-2]};
   assign trial  = {2'b0, root_ff, 2'b01};
   assign take   = (rem_sh >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff <= {rad_ff[RAD_W-3:0], 2'b00};
         if (take) begin
            rem_ff  <= 66'(rem_sh - trial);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh[65:0];
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== hw/rtl/dtsa_checker.sv =====
// Port-level checker for the triangulated surface area unit, bound to the top.
// Uses dtsa_pkg.
module dtsa_checker import dtsa_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [AREA_W-1:0] rsp_total_area
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("Result transaction dropped while stalled.");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_total_area))
      else $error("Result payload changed while stalled.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("Input accepted while a transaction is in progress.");

   a_reset_quiet: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("Result valid right after reset.");

endmodule

bind dem_triangulated_surface_area_unit dtsa_checker u_dtsa_checker (.*);

// ===== tb/dem_triangulated_surface_area_unit_test.sv =====
// Testbench for the triangulated surface area unit: random rasters and settings
// are checked against a behavioral predictor held in a small scoreboard class.
// Depends on dtsa_pkg and the dem_triangulated_surface_area_unit RTL.
`timescale 1ns / 100ps

module dem_triangulated_surface_area_unit_test;
   import dtsa_pkg::*;

   localparam int MAXC = MAX_COLUMNS_DEFAULT;
   localparam logic [63:0] SUM_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

   class area_scoreboard;
      int unsigned cols_reg;
      logic [23:0] ew, ns, scale;
      logic        diag;
      logic signed [23:0] line_buf [MAXC];
      logic signed [23:0] left_cur, left_up;
      int unsigned col_pos;
      bit          top_row;
      logic [63:0] running;
      logic [62:0] pending_areas [$];
      int unsigned errors;
      int unsigned checked;

      function void clear();
         left_cur = 0;
         left_up = 0;
         col_pos = 0;
         top_row = 1;
         running = 0;
      endfunction

      function void init();
         cols_reg = 4096;
         ew = 256;
         ns = 256;
         scale = 65536;
         diag = 0;
         foreach (line_buf[i]) line_buf[i] = 0;
         clear();
         errors = 0;
         checked = 0;
      endfunction

      function logic [63:0] component(logic [63:0] k, longint d);
         logic [127:0] p;
         logic [63:0] m;
         m = (d < 0) ? -d : d;
         p = k * m;
         return p[72:9];
      endfunction

      function logic [63:0] tri_area(longint dn, longint de);
         logic [127:0] h1, h2, h3, total, sq;
         logic [63:0] r, c;
         h1 = component(64'(ns) * 64'(scale), dn);
         h2 = component(64'(ew) * 64'(scale), de);
         h3 = (64'(ew) * 64'(ns)) >> 1;
         total = h1 * h1 + h2 * h2 + h3 * h3;
         r = 0;
         for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            sq = 128'(c) * 128'(c);
            if (sq <= total) r = c;
         end
         return r;
      endfunction

      function void add_area(logic [63:0] a);
         if (a > SUM_LIMIT - running) running = SUM_LIMIT;
         else running = running + a;
      endfunction

      function void note_sample(logic signed [23:0] e, logic last);
         int unsigned n, c;
         longint t0, t1, b0, b1;
         logic signed [23:0] above;
         n = cols_reg < 2 ? 2 : (cols_reg > MAXC ? MAXC : cols_reg);
         c = col_pos >= n ? 0 : col_pos;
         above = line_buf[c];
         if (!top_row && c > 0) begin
            t0 = left_up;
            t1 = above;
            b0 = left_cur;
            b1 = e;
            if (diag) begin
               add_area(tri_area(t1 - t0, t1 - b1));
               add_area(tri_area(b0 - b1, b0 - t0));
            end else begin
               add_area(tri_area(t0 - t1, t0 - b0));
               add_area(tri_area(b1 - b0, b1 - t1));
            end
         end
         left_up = above;
         left_cur = e;
         line_buf[c] = e;
         c++;
         if (c >= n) begin
            c = 0;
            top_row = 0;
         end
         col_pos = c;
         if (last) begin
            pending_areas.push_back(running[62:0]);
            clear();
         end
      endfunction

      function void check_area(logic [62:0] got);
         logic [62:0] want;
         if (pending_areas.size() == 0) begin
            report("unexpected transaction", got, 0);
            return;
         end
         want = pending_areas.pop_front();
         checked++;
         if (got !== want) report("total_area mismatch", got, want);
      endfunction

      function void report(string what, logic [62:0] got, logic [62:0] want);
         errors++;
         $display("ERROR %s: got %0d expected %0d", what, got, want);
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall, req_last_of_map = 0;
   logic signed [23:0] req_elevation = 0;
   logic rsp_valid, rsp_stall = 0;
   logic [62:0] rsp_total_area;
   logic psel = 0, penable = 0, pwrite = 0, pready;
   logic [4:0] paddr = 0;
   logic [31:0] pwdata = 0, prdata;

   area_scoreboard board;
   bit quiet = 0;
   int unsigned samples = 0, maps = 0;

   dem_triangulated_surface_area_unit dut (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #400ms;
      $display("Verification failed");
      $finish;
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) board.check_area(rsp_total_area);

   initial begin
      int n;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 15) == 0) begin
            n = $urandom_range(1, 16);
            rsp_stall <= 1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 0;
      end
   end

   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      @(negedge clock);
      psel <= 1;
      pwrite <= 1;
      penable <= 0;
      paddr <= 5'(idx) << 2;
      pwdata <= value;
      @(negedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_COLUMNS: board.cols_reg = value[12:0];
         REG_EW: board.ew = value[23:0];
         REG_NS: board.ns = value[23:0];
         REG_SCALE: board.scale = value[23:0];
         default: board.diag = value[0];
      endcase
      @(negedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
   endtask

   task automatic send_sample(logic signed [23:0] e, logic last);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid <= 1;
      req_elevation <= e;
      req_last_of_map <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_sample(e, last);
      samples++;
      if (last) maps++;
      @(negedge clock);
   endtask

   task automatic drain();
      int guard;
      @(negedge clock);
      req_valid <= 0;
      guard = 0;
      while (board.pending_areas.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      repeat (400) @(negedge clock);
   endtask

   function automatic logic signed [23:0] pick_elev(int mode);
      case (mode)
         0: return 24'sh7FFFFF;
         1: return -24'sh800000;
         2: return 24'($urandom);
         default: return 24'($signed($urandom_range(0, 200)) - 100);
      endcase
   endfunction

   task automatic send_map(int cols, int rows, int mode);
      for (int i = 0; i < cols * rows; i++)
         send_sample(pick_elev(mode == 4 ? $urandom_range(0, 3) : mode), i == cols * rows - 1);
   endtask

   initial begin
      int cols;
      board = new();
      board.init();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed rasters: extreme elevations, both diagonals, tiny rows.
      write_reg(REG_COLUMNS, 3);
      send_map(3, 2, 0);
      send_map(3, 2, 1);
      for (int i = 0; i < 6; i++) send_sample(i[0] ? 24'sh7FFFFF : -24'sh800000, i == 5);
      drain();
      write_reg(REG_DIAGONAL, 1);
      for (int i = 0; i < 6; i++) send_sample(i[0] ? -24'sh800000 : 24'sh7FFFFF, i == 5);
      send_sample(5, 1);
      drain();
      // Row length below range acts as two; maxima of spacing and scale saturate.
      write_reg(REG_COLUMNS, 0);
      write_reg(REG_EW, 24'hFFFFFF);
      write_reg(REG_NS, 24'hFFFFFF);
      write_reg(REG_SCALE, 24'hFFFFFF);
      send_map(2, 6, 4);
      drain();
      write_reg(REG_COLUMNS, 8191);
      write_reg(REG_EW, 0);
      write_reg(REG_SCALE, 0);
      send_sample(10, 0);
      send_sample(20, 1);
      drain();
      write_reg(REG_EW, 1);
      write_reg(REG_NS, 1);
      write_reg(REG_SCALE, 1);
      write_reg(REG_COLUMNS, 4);
      send_map(4, 2, 3);
      drain();
      // A shorter row mid-raster wraps the column index.
      send_sample(1, 0); send_sample(2, 0); send_sample(3, 0);
      drain();
      write_reg(REG_COLUMNS, 2);
      send_sample(4, 0); send_sample(5, 0); send_sample(6, 1);
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         write_reg(REG_COLUMNS, phase == 9 ? 200 : $urandom_range(2, 9));
         write_reg(REG_EW, phase < 2 ? $urandom_range(1, 1024) : $urandom);
         write_reg(REG_NS, phase < 2 ? $urandom_range(1, 1024) : $urandom);
         write_reg(REG_SCALE, phase == 3 ? 24'hFFFFFF : $urandom);
         write_reg(REG_DIAGONAL, phase[0]);
         cols = board.cols_reg < 2 ? 2 : board.cols_reg;
         if (phase == 9) begin
            quiet = 1;
            send_map(cols, 2, 4);
            for (int i = 0; i < 6; i++) send_sample(pick_elev(3), i == 5);
         end else begin
            for (int m = 0; m < 7; m++) begin
               send_map(cols, $urandom_range(1, 4), m == 6 ? 2 : 4);
               if (m == 3) begin
                  req_valid <= 0;
                  while (board.pending_areas.size() != 0) @(negedge clock);
               end
            end
            send_sample(pick_elev(2), 0);
            send_sample(pick_elev(2), 1);
         end
         drain();
      end

      $display("Covered %0d samples in %0d rasters; %0d totals compared.",
               samples, maps, board.checked);
      if (board.errors == 0 && board.pending_areas.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
